>>> rtl/core/scst_pkg.sv
// ----------------------------------------------------------------------------
// scst_pkg
// Shared types and constants of the shot capture sequencer with timers.
// ----------------------------------------------------------------------------
`default_nettype none

package scst_pkg;

   localparam int NUM_SLOTS    = 12;
   localparam int SENSOR_WIDTH = 8;

   localparam logic [7:0] SENSOR_MASK = 8'((16'd1 << SENSOR_WIDTH) - 16'd1);

   localparam logic [15:0] RING_QUIET_RESET  = 16'd50;
   localparam logic [15:0] WAIT_LIMIT_RESET  = 16'd10;
   localparam logic [7:0]  PRESENT_MASK_RESET = 8'd255;

   typedef enum logic [1:0] {
      OP_TICK = 2'd0,
      OP_ADD  = 2'd1,
      OP_DEL  = 2'd2,
      OP_READ = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      CSR_RING_QUIET   = 2'd0,
      CSR_WAIT_LIMIT   = 2'd1,
      CSR_PRESENT_MASK = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      PH_IDLE = 3'b001,
      PH_WAIT = 3'b010,
      PH_DONE = 3'b100
   } phase_type;

   localparam logic [1:0] STATE_IDLE = 2'd0;
   localparam logic [1:0] STATE_WAIT = 2'd1;
   localparam logic [1:0] STATE_DONE = 2'd2;

   typedef struct packed {
      logic tick;
      logic all_present;
      logic any_sensor;
      logic countdown_zero;
   } status_type;

   typedef struct packed {
      logic       acquire;
      logic       reject;
      logic       rearm;
      logic       load_ring;
      logic       load_wait;
      logic [1:0] state_code;
   } command_type;

endpackage

`default_nettype wire

>>> rtl/core/shot_capture_sequencer_with_timers_top.sv
// Result: a result is held in the output register from the cycle after its request transfer.
// Throughput: one item per cycle while rsp_tready holds; the slot bank compares and counts all 12 slots in parallel.
// The output register takes a new item in the cycle its previous result is transferred.
// Reset (synchronous, active high) clears the phase to idle, the countdown to zero, all slots
// to free and the configuration to ring quiet 50, wait limit 10, present mask 0xFF.
// ----------------------------------------------------------------------------
// shot_capture_sequencer_with_timers_top
// Tick-driven shot capture sequencer with a bank of countdown timer slots.
// ----------------------------------------------------------------------------
`default_nettype none

module shot_capture_sequencer_with_timers_top
   import scst_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,   // sensor_bits[7:0], timer_id[15:8], duration[47:16]
   input  wire logic [1:0]  req_tuser,   // opcode[1:0]
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,   // acquire_pulse[0], reject_pulse[1], rearm_pulse[2],
                                         // capture_state[4:3], op_ok[5], timer_value[37:6]
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_data
);

   status_type  status;
   command_type command;

   scst_ctrl u_ctrl (
      .clock   (clock),
      .reset   (reset),
      .status  (status),
      .command (command)
   );

   scst_datapath u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .command    (command),
      .status     (status)
   );

endmodule

`default_nettype wire

>>> rtl/core/scst_ctrl.sv
// ----------------------------------------------------------------------------
// scst_ctrl
// Capture phase machine: idle, waiting for all sensors or the wait limit, done and ringing.
// ----------------------------------------------------------------------------
`default_nettype none

module scst_ctrl
   import scst_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire status_type  status,
   output command_type      command
);

   phase_type phase_ff;
   phase_type phase_in;

   always_comb begin
      command  = '0;
      phase_in = phase_ff;
      if (status.tick) begin
         case (phase_ff)
            PH_WAIT: begin
               if (status.all_present || status.countdown_zero) begin
                  command.acquire   = 1'b1;
                  command.load_ring = 1'b1;
                  phase_in          = PH_DONE;
               end
            end
            PH_DONE: begin
               if (status.any_sensor) begin
                  command.reject    = 1'b1;
                  command.load_ring = 1'b1;
               end else if (status.countdown_zero) begin
                  command.rearm = 1'b1;
                  phase_in      = PH_IDLE;
               end
            end
            default: begin
               phase_in = PH_IDLE;
               if (status.any_sensor) begin
                  command.load_wait = 1'b1;
                  phase_in          = PH_WAIT;
               end
            end
         endcase
      end
      case (phase_in)
         PH_WAIT: command.state_code = STATE_WAIT;
         PH_DONE: command.state_code = STATE_DONE;
         default: command.state_code = STATE_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/scst_datapath.sv
// ----------------------------------------------------------------------------
// scst_datapath
// Configuration registers, phase countdown, timer slot bank and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module scst_datapath
   import scst_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [47:0] req_tdata,
   input  wire logic [1:0]  req_tuser,
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [39:0]      rsp_tdata,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [1:0]  csr_index,
   input  wire logic [15:0] csr_data,
   input  wire command_type command,
   output status_type       status
);

   logic [15:0] ring_quiet_ff;
   logic [15:0] wait_limit_ff;
   logic [7:0]  present_mask_ff;
   logic [15:0] countdown_ff;
   logic [15:0] countdown_in;

   logic [NUM_SLOTS-1:0] in_use_ff;
   logic [NUM_SLOTS-1:0] in_use_in;
   logic [7:0]           owner_ff [NUM_SLOTS];
   logic [7:0]           owner_in [NUM_SLOTS];
   logic [31:0]          count_ff [NUM_SLOTS];
   logic [31:0]          count_in [NUM_SLOTS];

   logic                 rsp_valid_ff;
   logic [39:0]          rsp_data_ff;
   logic [39:0]          rsp_data_in;

   logic                 accept;
   opcode_type           opcode;
   logic [7:0]           sensors;
   logic [7:0]           timer_id;
   logic [31:0]          duration;

   logic [NUM_SLOTS-1:0] free_or_match;
   logic [NUM_SLOTS-1:0] live_match;
   logic [NUM_SLOTS-1:0] add_sel;
   logic [NUM_SLOTS-1:0] live_sel;
   logic [NUM_SLOTS-1:0] one_lsb;
   logic                 op_ok;
   logic [31:0]          read_value;
   logic [31:0]          timer_value;

   assign one_lsb    = {{(NUM_SLOTS-1){1'b0}}, 1'b1};
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign accept     = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   assign opcode   = opcode_type'(req_tuser);
   assign sensors  = req_tdata[7:0] & SENSOR_MASK;
   assign timer_id = req_tdata[15:8];
   assign duration = req_tdata[47:16];

   assign status.tick           = accept && (opcode == OP_TICK);
   assign status.all_present    = (sensors == present_mask_ff);
   assign status.any_sensor     = (sensors != 8'd0);
   assign status.countdown_zero = (countdown_ff == 16'd0);

   always_comb begin
      for (int i = 0; i < NUM_SLOTS; i++) begin
         free_or_match[i] = !in_use_ff[i] || (owner_ff[i] == timer_id);
         live_match[i]    = in_use_ff[i] && (owner_ff[i] == timer_id);
      end
   end

   assign add_sel  = free_or_match & (~free_or_match + one_lsb);
   assign live_sel = live_match & (~live_match + one_lsb);

   always_comb begin
      read_value = '0;
      for (int i = 0; i < NUM_SLOTS; i++) begin
         read_value = read_value | (count_ff[i] & {32{live_sel[i]}});
      end
   end

   always_comb begin
      op_ok       = 1'b0;
      timer_value = '0;
      case (opcode)
         OP_ADD:  op_ok = |free_or_match;
         OP_DEL:  op_ok = |live_match;
         OP_READ: begin
            op_ok       = |live_match;
            timer_value = read_value;
         end
         default: op_ok = 1'b0;
      endcase
   end

   always_comb begin
      countdown_in = countdown_ff;
      if (command.load_ring) begin
         countdown_in = ring_quiet_ff;
      end else if (command.load_wait) begin
         countdown_in = wait_limit_ff;
      end else if (status.tick && !status.countdown_zero) begin
         countdown_in = countdown_ff - 16'd1;
      end
   end

   always_comb begin
      in_use_in = in_use_ff;
      owner_in  = owner_ff;
      count_in  = count_ff;
      if (accept) begin
         case (opcode)
            OP_TICK: begin
               for (int i = 0; i < NUM_SLOTS; i++) begin
                  if (in_use_ff[i] && (count_ff[i] != 32'd0)) begin
                     count_in[i] = count_ff[i] - 32'd1;
                  end
               end
            end
            OP_ADD: begin
               for (int i = 0; i < NUM_SLOTS; i++) begin
                  if (add_sel[i]) begin
                     in_use_in[i] = 1'b1;
                     owner_in[i]  = timer_id;
                     count_in[i]  = duration;
                  end
               end
            end
            OP_DEL: begin
               in_use_in = in_use_ff & ~live_sel;
            end
            default: begin
               in_use_in = in_use_ff;
            end
         endcase
      end
   end

   assign rsp_data_in = {2'b00, timer_value, op_ok, command.state_code,
                         command.rearm, command.reject, command.acquire};

   always_ff @(posedge clock) begin
      owner_ff <= owner_in;
      count_ff <= count_in;
      if (accept) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_quiet_ff   <= RING_QUIET_RESET;
         wait_limit_ff   <= WAIT_LIMIT_RESET;
         present_mask_ff <= PRESENT_MASK_RESET;
         countdown_ff    <= '0;
         in_use_ff       <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_RING_QUIET:   ring_quiet_ff   <= csr_data;
               CSR_WAIT_LIMIT:   wait_limit_ff   <= csr_data;
               CSR_PRESENT_MASK: present_mask_ff <= csr_data[7:0];
               default:          ring_quiet_ff   <= ring_quiet_ff;
            endcase
         end
         countdown_ff <= countdown_in;
         in_use_ff    <= in_use_in;
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

`default_nettype wire

>>> rtl/core/scst_checker.sv
// ----------------------------------------------------------------------------
// scst_checker
// Port-level checks of the shot capture sequencer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module scst_checker
   import scst_pkg::*;
(
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [39:0] rsp_tdata
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result changed while stalled");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |-> !rsp_tvalid || rsp_tready)
      else $error("request taken while result stalled");

   a_one_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> $onehot0(rsp_tdata[2:0]))
      else $error("more than one capture pulse");

   a_pulse_state: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[0] || rsp_tdata[1]) |-> rsp_tdata[4:3] == STATE_DONE)
      else $error("acquire or reject without done state");

   a_pulse_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tdata[2:0] != 3'd0) |->
         !rsp_tdata[5] && (rsp_tdata[37:6] == 32'd0))
      else $error("tick result carries slot status");

endmodule

bind shot_capture_sequencer_with_timers_top scst_checker u_scst_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
